// ----- rtl/rcpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_pkg: shared types and constants
// fixed point formats, item kinds and divider request/response structs
// ----------------------------------------------------------------------------
package rcpc_pkg;
  localparam int CW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * CW;       // one exact product
  localparam int SW = PW + 3;       // sum of up to six products
  localparam int NW = SW + FB;      // shifted dividend width
  localparam int QCW = $clog2(NW + 1);
  localparam logic signed [CW-1:0] TMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] TMIN = {1'b1, {(CW-1){1'b0}}};

  // item kinds on the mode field
  localparam logic MODE_SETUP = 1'b0;
  localparam logic MODE_FACE  = 1'b1;

  typedef struct packed {
    logic          start;
    logic [SW-1:0] num_mag;
    logic [SW-1:0] den_mag;
    logic          neg;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/rcpc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcpc_div: iterative restoring divider
// one quotient bit per cycle, signed result saturated to the coordinate range
// ----------------------------------------------------------------------------
module rcpc_div
  import rcpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [NW-1:0]  num;
  logic [SW:0]    rem;
  logic [NW-1:0]  quo;
  logic [SW-1:0]  den;
  logic           neg;
  logic [QCW-1:0] cnt;
  logic           busy;
  logic [SW:0]    trial;
  logic [SW:0]    diff;
  logic [NW-1:0]  qn;
  logic           sat;

  assign trial = {rem[SW-1:0], num[NW-1]};
  assign diff  = trial - {1'b0, den};
  assign qn    = {quo[NW-2:0], ~diff[SW]};
  assign sat   = neg ? (quo > NW'({1'b1, {(CW-1){1'b0}}}))
                     : (quo > NW'(TMAX));

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= QCW'(NW);
      num  <= {req.num_mag, {FB{1'b0}}};
      den  <= req.den_mag;
      neg  <= req.neg;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      if (cnt == '0) begin
        busy     <= 1'b0;
        rsp.done <= 1'b1;
        if (sat) rsp.quot <= neg ? TMIN : TMAX;
        else     rsp.quot <= neg ? -quo[CW-1:0] : quo[CW-1:0];
      end else begin
        rem <= diff[SW] ? trial : diff;
        quo <= qn;
        num <= {num[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/ray_convex_polyhedron_clip_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ray_convex_polyhedron_clip_core: ray against convex polyhedron, slab clip
// shared multiplier forms dot products, shared divider gives face t
// ----------------------------------------------------------------------------
// channel  signals                                     dir
// in       in_valid, in_stall, mode, vec_a_*, vec_b_*,  in
//          nearest_so_far, last_face
// out      out_valid, out_stall, hit, nearest_out,     out
//          normal_x/y/z
// set-up item: taken while idle. face item: multiply steps, a check of the denominator,
// a divide (83 quotient bits one per cycle, load and done) and a finish
// a parallel face skips the divide, a face after a miss goes straight to the finish
// rst is synchronous; it re-arms the interval and empties the output register.
// in_stall is high while an item is in work; a last face holds in its final
// cycle while the previous result waits on out_stall.
// ----------------------------------------------------------------------------
module ray_convex_polyhedron_clip_core
  import rcpc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 mode,
  input  wire logic signed [CW-1:0] vec_a_x,
  input  wire logic signed [CW-1:0] vec_a_y,
  input  wire logic signed [CW-1:0] vec_a_z,
  input  wire logic signed [CW-1:0] vec_b_x,
  input  wire logic signed [CW-1:0] vec_b_y,
  input  wire logic signed [CW-1:0] vec_b_z,
  input  wire logic [CW-2:0]        nearest_so_far,
  input  wire logic                 last_face,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      hit,
  output logic [CW-2:0]             nearest_out,
  output logic signed [CW-1:0]      normal_x,
  output logic signed [CW-1:0]      normal_y,
  output logic signed [CW-1:0]      normal_z
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_WAIT, S_FIN} state_t;

  state_t               state;
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];
  logic signed [CW-1:0] na  [3];
  logic signed [CW-1:0] pb  [3];
  logic signed [CW-1:0] enorm [3];
  logic [CW-2:0]        near_b;
  logic signed [CW-1:0] t_en, t_ex;
  logic                 missed;
  logic                 lastf;
  logic [3:0]           step;
  logic signed [SW-1:0] denom, dist_acc;
  logic signed [CW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic [1:0]           k;
  logic [1:0]           kind;
  div_req_t             dreq;
  div_rsp_t             drsp;
  logic                 acc;
  logic signed [CW-1:0] t;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign k        = step[3:2];
  assign kind     = step[1:0];
  assign prod     = ma * mb;
  assign t        = drsp.quot;

  always_comb begin
    ma = na[k];
    unique case (kind)
      2'd0:    mb = dir[k];
      2'd1:    mb = pb[k];
      default: mb = org[k];
    endcase
  end

  always_comb begin
    dreq.start   = (state == S_WAIT) && (denom != '0);
    dreq.num_mag = dist_acc[SW-1] ? SW'(-dist_acc) : SW'(dist_acc);
    dreq.den_mag = denom[SW-1] ? SW'(-denom) : SW'(denom);
    dreq.neg     = dist_acc[SW-1] ^ denom[SW-1];
  end

  rcpc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      missed    <= 1'b0;
      t_en      <= '0;
      t_ex      <= TMAX;
      near_b    <= TMAX[CW-2:0];
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0; dir[i] <= '0; enorm[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (acc) begin
          if (mode == MODE_SETUP) begin
            org[0] <= vec_a_x; org[1] <= vec_a_y; org[2] <= vec_a_z;
            dir[0] <= vec_b_x; dir[1] <= vec_b_y; dir[2] <= vec_b_z;
            near_b <= nearest_so_far;
            t_en   <= '0;
            t_ex   <= TMAX;
            missed <= 1'b0;
            for (int i = 0; i < 3; i++) enorm[i] <= '0;
          end else begin
            na[0] <= vec_a_x; na[1] <= vec_a_y; na[2] <= vec_a_z;
            pb[0] <= vec_b_x; pb[1] <= vec_b_y; pb[2] <= vec_b_z;
            lastf <= last_face;
            denom <= '0;
            dist_acc <= '0;
            step  <= '0;
            state <= missed ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          unique case (kind)
            2'd0:    denom <= denom + SW'(prod);
            2'd1:    dist_acc <= dist_acc + SW'(prod);
            default: dist_acc <= dist_acc - SW'(prod);
          endcase
          if (kind == 2'd2) step <= {k + 2'd1, 2'd0};
          else step <= step + 4'd1;
          if (step == 4'd10) state <= S_WAIT;
        end
        S_WAIT: begin
          if (denom == '0) begin
            if (dist_acc[SW-1]) missed <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (denom[SW-1]) begin
              if (t_en < t) begin
                t_en <= t;
                enorm <= na;
              end
              if (t_ex < t) missed <= 1'b1;
            end else begin
              if (t < t_ex) t_ex <= t;
              if (t < t_en) missed <= 1'b1;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!lastf) begin
            state <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
            if (!missed && (t_en < $signed({1'b0, near_b}))) begin
              hit <= 1'b1;
              nearest_out <= t_en[CW-2:0];
              near_b <= t_en[CW-2:0];
              normal_x <= enorm[0]; normal_y <= enorm[1]; normal_z <= enorm[2];
            end else begin
              hit <= 1'b0;
              nearest_out <= near_b;
              normal_x <= '0; normal_y <= '0; normal_z <= '0;
            end
            t_en   <= '0;
            t_ex   <= TMAX;
            missed <= 1'b0;
            for (int i = 0; i < 3; i++) enorm[i] <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(nearest_out)))
    else $error("result lost");
  a_miss_norm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("normal on miss");
endmodule
`default_nettype wire
